### rtl/core/lwt_pkg.sv
// ----------------------------------------------------------------------------
// lwt_pkg: shared definitions of the lane window tracker
// Field widths, register indexes, reset values and the side accumulator
// control word.
// ----------------------------------------------------------------------------
`default_nettype none

package lwt_pkg;

    // Field and register widths
    localparam int CTR_W      = 13;
    localparam int WIN_IDX_W  = 6;
    localparam int IW_W       = 13;
    localparam int WW_W       = 11;
    localparam int MC_W       = 11;
    localparam int NW_W       = 7;
    localparam int CNT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Default largest row length
    localparam int DEF_MAX_WIDTH = 4096;

    // Saturation of the window pixel counts
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Window row limits
    localparam logic [NW_W-1:0] NW_MIN = NW_W'(1);
    localparam logic [NW_W-1:0] NW_MAX = NW_W'(64);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_WINDOWS  = 2'd3;

    // Register reset values
    localparam logic [IW_W-1:0] RST_IMAGE_WIDTH  = IW_W'(640);
    localparam logic [WW_W-1:0] RST_WINDOW_WIDTH = WW_W'(63);
    localparam logic [MC_W-1:0] RST_MIN_COUNT    = MC_W'(6);
    localparam logic [NW_W-1:0] RST_NUM_WINDOWS  = NW_W'(12);

    // Control word of one side accumulator
    typedef struct packed {
        logic en;       // a word is processed this cycle
        logic restart;  // frame start: forget the stored row
        logic note;     // the current pixel falls on this side
        logic flush;    // row closed: clear after this word
    } t_side_ctl;

endpackage

`default_nettype wire

### rtl/core/lwt_pix_if.sv
// ----------------------------------------------------------------------------
// lwt_pix_if: pixel channel
// Valid/ready channel carrying one binary pixel with row and frame marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface lwt_pix_if;
    logic valid;
    logic ready;
    logic pixel_set;
    logic row_end;
    logic frame_start;

    modport source (output valid, output pixel_set, output row_end,
                    output frame_start, input ready);
    modport sink   (input valid, input pixel_set, input row_end,
                    input frame_start, output ready);
endinterface

`default_nettype wire

### rtl/core/lwt_res_if.sv
// ----------------------------------------------------------------------------
// lwt_res_if: result channel
// Valid/ready channel carrying the lane centres of one window row.
// ----------------------------------------------------------------------------
`default_nettype none

interface lwt_res_if
    import lwt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CTR_W-1:0]     left_center;
    logic [CTR_W-1:0]     right_center;
    logic [CTR_W-1:0]     mid_center;
    logic [WIN_IDX_W-1:0] window_index;
    logic                 last;

    modport source (output valid, output left_center, output right_center,
                    output mid_center, output window_index, output last,
                    input ready);
    modport sink   (input valid, input left_center, input right_center,
                    input mid_center, input window_index, input last,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/lwt_side_acc.sv
// ----------------------------------------------------------------------------
// lwt_side_acc: per-side window accumulator
// Counts set pixels on one side and keeps the first and last of them.
// Outputs give the values with the current pixel already included.
// ----------------------------------------------------------------------------
`default_nettype none

module lwt_side_acc
    import lwt_pkg::*;
#(
    parameter int COL_W = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_side_ctl        i_ctl,
    input  wire logic [COL_W-1:0] i_col,
    output logic                  o_found,
    output logic [COL_W-1:0]      o_first,
    output logic [COL_W-1:0]      o_last,
    output logic [CNT_W-1:0]      o_count
);

    logic             r_found;
    logic [COL_W-1:0] r_first;
    logic [COL_W-1:0] r_last;
    logic [CNT_W-1:0] r_count;

    logic             b_found;
    logic [COL_W-1:0] b_first;
    logic [COL_W-1:0] b_last;
    logic [CNT_W-1:0] b_count;

    // Start from the stored row, or from nothing on a frame start
    always_comb begin
        b_found = i_ctl.restart ? 1'b0 : r_found;
        b_first = i_ctl.restart ? '0 : r_first;
        b_last  = i_ctl.restart ? '0 : r_last;
        b_count = i_ctl.restart ? '0 : r_count;
    end

    // Fold in the current pixel
    always_comb begin
        o_found = b_found;
        o_first = b_first;
        o_last  = b_last;
        o_count = b_count;
        if (i_ctl.note) begin
            o_found = 1'b1;
            o_first = b_found ? b_first : i_col;
            o_last  = i_col;
            if (b_count != COUNT_MAX) begin
                o_count = b_count + CNT_W'(1);
            end
        end
    end

    // Hold the running values, clear when the row closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_first <= '0;
            r_last  <= '0;
            r_count <= '0;
        end else if (i_ctl.en) begin
            if (i_ctl.flush) begin
                r_found <= 1'b0;
                r_first <= '0;
                r_last  <= '0;
                r_count <= '0;
            end else begin
                r_found <= o_found;
                r_first <= o_first;
                r_last  <= o_last;
                r_count <= o_count;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/lane_window_tracker_core.sv
// ----------------------------------------------------------------------------
// lane_window_tracker_core: sliding window lane search
// Tracks the left and right lane centres over the rows of a binary image.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix carries one binary pixel per word, with row_end on the last pixel
//   of a row and frame_start on the first pixel of the bottom row. The
//   bottom row seeds both centres; each window row up to the row limit is
//   searched in one window per side and, at its row end, one word leaves on
//   o_res with the centres, their midpoint, the window row number and a last flag.
//   Registers are written on i_cfg_we at index i_cfg_idx, unchecked; the user must write them only while idle.
//   Throughput: one pixel per cycle while no row-end pixel waits for the
//   result register. Each pixel passes an input register and is folded
//   into the running state as it leaves that register; a window row-end
//   pixel leaving it also loads the result register with the result word.
//   When the receiver stalls, a waiting result holds in the result
//   register and pixels keep flowing until a row-end pixel that needs the
//   result register reaches the input register; that pixel holds there
//   and i_pix.ready stays low until the waiting result is taken.
//   Reset (synchronous, active low) restores the register defaults and
//   clears all tracking state; rows are ignored until a frame start.
// ----------------------------------------------------------------------------
`default_nettype none

module lane_window_tracker_core
    import lwt_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lwt_pix_if.sink                    i_pix,
    lwt_res_if.source                  o_res
);

    localparam int               COL_W   = $clog2(MAX_WIDTH);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_WIDTH - 1);
    localparam int               WIN_W   = CTR_W + 1;

    // Configuration registers
    logic [IW_W-1:0] r_image_width;
    logic [WW_W-1:0] r_window_width;
    logic [MC_W-1:0] r_min_count;
    logic [NW_W-1:0] r_num_windows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_window_width <= RST_WINDOW_WIDTH;
            r_min_count    <= RST_MIN_COUNT;
            r_num_windows  <= RST_NUM_WINDOWS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[IW_W-1:0];
                CFG_WINDOW_WIDTH: r_window_width <= i_cfg_data[WW_W-1:0];
                CFG_MIN_COUNT:    r_min_count    <= i_cfg_data[MC_W-1:0];
                CFG_NUM_WINDOWS:  r_num_windows  <= i_cfg_data[NW_W-1:0];
            endcase
        end
    end

    // Input register
    logic r_in_valid;
    logic r_in_pix;
    logic r_in_rend;
    logic r_in_fstart;
    logic go;
    logic emit;
    logic out_free;

    assign i_pix.ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_in_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.ready && i_pix.valid) begin
            r_in_pix    <= i_pix.pixel_set;
            r_in_rend   <= i_pix.row_end;
            r_in_fstart <= i_pix.frame_start;
        end
    end

    // Tracking state
    logic [COL_W-1:0]     r_column;
    logic [CTR_W-1:0]     r_left_ctr;
    logic [CTR_W-1:0]     r_right_ctr;
    logic [WIN_IDX_W-1:0] r_win_row;
    logic                 r_in_init;
    logic                 r_tracking;

    logic [COL_W-1:0]     n_column;
    logic [CTR_W-1:0]     n_left_ctr;
    logic [CTR_W-1:0]     n_right_ctr;
    logic [WIN_IDX_W-1:0] n_win_row;
    logic                 n_in_init;
    logic                 n_tracking;
    logic                 n_last;

    // Effective view of the state for this word
    logic [COL_W-1:0] col;
    logic             init_row;
    logic             trk_row;

    assign col      = r_in_fstart ? '0 : r_column;
    assign init_row = r_in_fstart || r_in_init;
    assign trk_row  = !r_in_fstart && r_tracking;

    assign emit     = trk_row && r_in_rend;
    assign out_free = !o_res.valid || o_res.ready;
    assign go       = r_in_valid && (!emit || out_free);

    // Window tests: ctr - m <= col < ctr + m
    logic [WIN_W-1:0] half_w;
    logic [WIN_W-1:0] col_w;
    logic             left_in_win;
    logic             right_in_win;
    logic             left_half;

    assign half_w = WIN_W'(r_window_width >> 1);
    assign col_w  = WIN_W'(col);

    assign left_in_win  = (col_w + half_w >= WIN_W'(r_left_ctr))
                       && (col_w < WIN_W'(r_left_ctr) + half_w);
    assign right_in_win = (col_w + half_w >= WIN_W'(r_right_ctr))
                       && (col_w < WIN_W'(r_right_ctr) + half_w);
    assign left_half    = WIN_W'(col) < WIN_W'(r_image_width >> 1);

    // Side accumulators
    t_side_ctl        left_ctl;
    t_side_ctl        right_ctl;
    logic             left_found;
    logic             right_found;
    logic [COL_W-1:0] left_first;
    logic [COL_W-1:0] left_last;
    logic [COL_W-1:0] right_first;
    logic [COL_W-1:0] right_last;
    logic [CNT_W-1:0] left_count;
    logic [CNT_W-1:0] right_count;

    always_comb begin
        left_ctl.en       = go;
        left_ctl.restart  = r_in_fstart;
        left_ctl.flush    = r_in_rend && (init_row || trk_row);
        left_ctl.note     = r_in_pix && ((init_row && left_half)
                                      || (!init_row && trk_row && left_in_win));
        right_ctl.en      = go;
        right_ctl.restart = r_in_fstart;
        right_ctl.flush   = r_in_rend && (init_row || trk_row);
        right_ctl.note    = r_in_pix && ((init_row && !left_half)
                                      || (!init_row && trk_row && right_in_win));
    end

    lwt_side_acc #(.COL_W(COL_W)) u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (left_ctl),
        .i_col   (col),
        .o_found (left_found),
        .o_first (left_first),
        .o_last  (left_last),
        .o_count (left_count)
    );

    lwt_side_acc #(.COL_W(COL_W)) u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (right_ctl),
        .i_col   (col),
        .o_found (right_found),
        .o_first (right_first),
        .o_last  (right_last),
        .o_count (right_count)
    );

    // Midpoints of the first and last set pixel
    logic [COL_W:0]   left_sum;
    logic [COL_W:0]   right_sum;
    logic [CTR_W-1:0] left_mid;
    logic [CTR_W-1:0] right_mid;

    assign left_sum  = {1'b0, left_first} + {1'b0, left_last};
    assign right_sum = {1'b0, right_first} + {1'b0, right_last};
    assign left_mid  = CTR_W'(left_sum >> 1);
    assign right_mid = CTR_W'(right_sum >> 1);

    // Window row limit, clamped to one..sixty-four
    logic [NW_W-1:0] nw_eff;
    logic            fin;

    always_comb begin
        nw_eff = r_num_windows;
        if (r_num_windows < NW_MIN) begin
            nw_eff = NW_MIN;
        end else if (r_num_windows > NW_MAX) begin
            nw_eff = NW_MAX;
        end
    end

    assign fin = (NW_W'(r_win_row) + NW_W'(1)) >= nw_eff;

    // Next state
    always_comb begin
        n_left_ctr  = r_left_ctr;
        n_right_ctr = r_right_ctr;
        n_in_init   = init_row;
        n_tracking  = trk_row;
        n_win_row   = r_in_fstart ? '0 : r_win_row;
        n_last      = 1'b0;
        if (init_row) begin
            if (r_in_rend) begin
                n_left_ctr  = left_found ? left_mid : '0;
                n_right_ctr = right_found ? right_mid : CTR_W'(r_image_width);
                n_in_init   = 1'b0;
                n_tracking  = 1'b1;
                n_win_row   = '0;
            end
        end else if (trk_row && r_in_rend) begin
            if (left_found && (left_count >= r_min_count)) begin
                n_left_ctr = left_mid;
            end
            if (right_found && (right_count >= r_min_count)) begin
                n_right_ctr = right_mid;
            end
            n_last = fin;
            if (fin) begin
                n_tracking = 1'b0;
                n_win_row  = '0;
            end else begin
                n_win_row = r_win_row + WIN_IDX_W'(1);
            end
        end
        if (r_in_rend) begin
            n_column = '0;
        end else if (col < COL_MAX) begin
            n_column = col + COL_W'(1);
        end else begin
            n_column = col;
        end
    end

    // Advance the state on every processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_left_ctr  <= '0;
            r_right_ctr <= '0;
            r_win_row   <= '0;
            r_in_init   <= 1'b0;
            r_tracking  <= 1'b0;
        end else if (go) begin
            r_column    <= n_column;
            r_left_ctr  <= n_left_ctr;
            r_right_ctr <= n_right_ctr;
            r_win_row   <= n_win_row;
            r_in_init   <= n_in_init;
            r_tracking  <= n_tracking;
        end
    end

    // Result register
    logic                 r_out_valid;
    logic [CTR_W-1:0]     r_out_left;
    logic [CTR_W-1:0]     r_out_right;
    logic [CTR_W-1:0]     r_out_mid;
    logic [WIN_IDX_W-1:0] r_out_index;
    logic                 r_out_last;
    logic                 load_out;
    logic [CTR_W:0]       ctr_sum;

    assign load_out = go && emit;
    assign ctr_sum  = {1'b0, n_left_ctr} + {1'b0, n_right_ctr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_left  <= n_left_ctr;
            r_out_right <= n_right_ctr;
            r_out_mid   <= CTR_W'(ctr_sum >> 1);
            r_out_index <= r_win_row;
            r_out_last  <= n_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.left_center  = r_out_left;
    assign o_res.right_center = r_out_right;
    assign o_res.mid_center   = r_out_mid;
    assign o_res.window_index = r_out_index;
    assign o_res.last         = r_out_last;

    // Checks
    a_init_trk_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_init && r_tracking))
        else $error("bottom row and window rows active together");

    a_col_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column <= COL_MAX)
        else $error("column beyond the row limit");

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && n_last) |=> !r_tracking)
        else $error("tracking continues after the final window row");

    a_row_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tracking |-> (r_win_row == '0))
        else $error("window row count left over outside tracking");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !load_out)
        else $error("result register loaded while a result waits");

endmodule

`default_nettype wire
